// File: src/nsr_pkg.sv
// Shared constants for the Newton square-root core: widths, defaults and status codes.
`default_nettype none

package nsr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ITER_W   = 7;

  localparam int unsigned MAX_ITERATIONS_DEF = 32;
  localparam int unsigned FRACTION_BITS_DEF  = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic [STATUS_W-1:0] ST_CONVERGED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_INPUT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIV   = 3'd4;

endpackage

`default_nettype wire

// File: src/newton_square_root_core.sv
// Newton-Raphson square root in signed fixed point, one transaction at a time.
//
// Each input transaction carries a signed radicand and a signed starting guess
// (FRACTION_BITS fraction bits); one result follows with the root, a status code
// and the number of Newton steps taken. A step runs a check state, a bit-serial
// shift-add square, a numerator state, a bit-serial restoring division (one
// quotient bit a cycle) and an update state; a zero or negative radicand skips
// the steps. A new transaction is taken once the previous item has moved into
// the output register, which holds the result until the consumer takes it.
// The tolerance register may be written only while the core is idle.
`default_nettype none

module newton_square_root_core #(
  parameter int unsigned MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRACTION_BITS  = nsr_pkg::FRACTION_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire        [nsr_pkg::TOL_W-1:0]      cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire signed [nsr_pkg::WORD_W-1:0]     radicand_i,
  input  wire signed [nsr_pkg::WORD_W-1:0]     start_guess_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [nsr_pkg::WORD_W-1:0]    root_o,
  output logic       [nsr_pkg::STATUS_W-1:0]   status_o,
  output logic       [nsr_pkg::ITER_W-1:0]     iterations_used_o
);

  localparam int unsigned W    = nsr_pkg::WORD_W;
  localparam int unsigned NW   = 2 * W - 1;   // numerator / quotient width
  localparam int unsigned RW   = W + 1;       // remainder width
  localparam int unsigned IW   = nsr_pkg::ITER_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_NUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [W-1:0] ONE_FX  = W'(1) << FRACTION_BITS;
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [2:0]                     state_q, state_d;
  logic [nsr_pkg::TOL_W-1:0]      tol_q;
  logic [W-1:0]                   x_q, x_d;
  logic [W-1:0]                   ax_q, ax_d;
  logic [W-2:0]                   v_q, v_d;
  logic [2*W-1:0]                 prod_q, prod_d;
  logic [NW-1:0]                  dvd_q, dvd_d;
  logic [RW-1:0]                  rem_q, rem_d;
  logic                           numneg_q, numneg_d;
  logic [5:0]                     cnt_q, cnt_d;
  logic [IW-1:0]                  steps_q, steps_d;
  logic [W-1:0]                   res_root_q, res_root_d;
  logic [nsr_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                           out_valid_q, out_valid_d;
  logic [W-1:0]                   root_q;
  logic [nsr_pkg::STATUS_W-1:0]   status_q;
  logic [IW-1:0]                  iter_q;
  logic                           out_load;

  // datapath terms
  logic [W-1:0]    x_abs;
  logic [W:0]      mul_sum;
  logic [NW-1:0]   sq;
  logic [NW-1:0]   vs;
  logic            num_neg;
  logic [RW+1:0]   div_trial;
  logic            div_ge;
  logic            q_neg;
  logic [NW+1:0]   x_next_wide;
  logic            in_range;
  logic [W-1:0]    x_next;
  logic [W-1:0]    gap_hi;
  logic [W-1:0]    gap_lo;
  logic            converged;

  always_comb begin
    x_abs   = x_q[W-1] ? (~x_q + W'(1)) : x_q;
    mul_sum = prod_q[0] ? ({1'b0, prod_q[2*W-1:W]} + {1'b0, ax_q})
                        : {1'b0, prod_q[2*W-1:W]};
    sq      = prod_q[NW-1:0];
    vs      = NW'(v_q) << FRACTION_BITS;
    num_neg = sq < vs;
    // remainder and next dividend bit against 2*|x|
    div_trial = {1'b0, rem_q, dvd_q[NW-1]} - {2'b00, ax_q, 1'b0};
    div_ge    = !div_trial[RW+1];
    q_neg     = numneg_q ^ x_q[W-1];
    x_next_wide = q_neg ? ({{(NW+2-W){x_q[W-1]}}, x_q} + {2'b00, dvd_q})
                        : ({{(NW+2-W){x_q[W-1]}}, x_q} - {2'b00, dvd_q});
    in_range = (x_next_wide[NW+1:W-1] == {(NW+3-W){x_next_wide[NW+1]}});
    if (in_range) begin
      x_next = x_next_wide[W-1:0];
    end else begin
      x_next = x_next_wide[NW+1] ? SAT_MIN : SAT_MAX;
    end
    // step size is the quotient magnitude unless the update saturated
    gap_hi = SAT_MAX - x_q;
    gap_lo = x_q - SAT_MIN;
    if (in_range) begin
      converged = dvd_q < NW'(tol_q);
    end else if (x_next_wide[NW+1]) begin
      converged = gap_lo < W'(tol_q);
    end else begin
      converged = gap_hi < W'(tol_q);
    end
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    ax_d         = ax_q;
    v_d          = v_q;
    prod_d       = prod_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    numneg_d     = numneg_q;
    cnt_d        = cnt_q;
    steps_d      = steps_q;
    res_root_d   = res_root_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          steps_d    = '0;
          res_root_d = '0;
          v_d        = radicand_i[W-2:0];
          x_d        = (start_guess_i == '0) ? ONE_FX : start_guess_i;
          if (radicand_i == '0) begin
            res_status_d = nsr_pkg::ST_ZERO_INPUT;
            state_d      = S_FIN;
          end else if (radicand_i[W-1]) begin
            res_status_d = nsr_pkg::ST_NEGATIVE;
            state_d      = S_FIN;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (steps_q == IW'(MAX_ITERATIONS)) begin
          res_root_d   = x_q;
          res_status_d = nsr_pkg::ST_LIMIT;
          state_d      = S_FIN;
        end else if (x_q == '0) begin
          res_root_d   = '0;
          res_status_d = nsr_pkg::ST_ZERO_DIV;
          state_d      = S_FIN;
        end else begin
          ax_d    = x_abs;
          prod_d  = {{W{1'b0}}, x_abs};
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = {mul_sum, prod_q[W-1:1]};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(W - 1)) begin
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        numneg_d = num_neg;
        dvd_d    = num_neg ? (vs - sq) : (sq - vs);
        rem_d    = '0;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        // quotient bits shift in behind the dividend bits
        rem_d = div_ge ? div_trial[RW-1:0] : {rem_q[RW-2:0], dvd_q[NW-1]};
        dvd_d = {dvd_q[NW-2:0], div_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NW - 1)) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        steps_d = steps_q + IW'(1);
        if (converged) begin
          res_root_d   = x_next;
          res_status_d = nsr_pkg::ST_CONVERGED;
          state_d      = S_FIN;
        end else begin
          x_d     = x_next;
          state_d = S_CHECK;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tol_q       <= nsr_pkg::TOL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    ax_q         <= ax_d;
    v_q          <= v_d;
    prod_q       <= prod_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    numneg_q     <= numneg_d;
    cnt_q        <= cnt_d;
    steps_q      <= steps_d;
    res_root_q   <= res_root_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      root_q   <= res_root_q;
      status_q <= res_status_q;
      iter_q   <= steps_q;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign root_o            = root_q;
  assign status_o          = status_q;
  assign iterations_used_o = iter_q;

  // Early-exit results carry no steps and a zero root.
  a_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == nsr_pkg::ST_ZERO_INPUT || status_o == nsr_pkg::ST_NEGATIVE)
      |-> (iterations_used_o == '0) && (root_o == '0))
    else $error("early exit result carries steps or a root");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iterations_used_o <= IW'(MAX_ITERATIONS)))
    else $error("step count beyond the iteration limit");

  a_converged_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == nsr_pkg::ST_CONVERGED) |-> (iterations_used_o != '0))
    else $error("convergence reported without a step");

  a_limit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == nsr_pkg::ST_LIMIT)
      |-> (iterations_used_o == IW'(MAX_ITERATIONS)))
    else $error("limit status before the limit was reached");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV) |-> !in_ready_o)
    else $error("input ready while an item is in progress");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the fixed-point Newton square-root core.
module testbench;

  localparam int unsigned ITER_LIMIT     = nsr_pkg::MAX_ITERATIONS_DEF;
  localparam int unsigned FRAC           = nsr_pkg::FRACTION_BITS_DEF;
  localparam longint      ROOT_MAX       = 64'sd2147483647;
  localparam longint      ROOT_MIN       = -64'sd2147483648;
  localparam int          WATCHDOG_LIMIT = 20000;
  // worst case item: 32 Newton steps at the iteration limit
  localparam int          DRAIN_CYCLES   = 3200;

  typedef struct packed {
    logic signed [nsr_pkg::WORD_W-1:0] radicand;
    logic signed [nsr_pkg::WORD_W-1:0] guess;
  } sqrt_request_t;

  typedef struct packed {
    logic signed [nsr_pkg::WORD_W-1:0] root;
    logic [nsr_pkg::STATUS_W-1:0]      status;
    logic [nsr_pkg::ITER_W-1:0]        iters;
  } sqrt_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [nsr_pkg::TOL_W-1:0]           cfg_wdata_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic signed [nsr_pkg::WORD_W-1:0]   radicand_i = '0;
  logic signed [nsr_pkg::WORD_W-1:0]   start_guess_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [nsr_pkg::WORD_W-1:0]   root_o;
  logic [nsr_pkg::STATUS_W-1:0]        status_o;
  logic [nsr_pkg::ITER_W-1:0]          iterations_used_o;

  sqrt_request_t              request_q[$];
  sqrt_result_t               expected_roots_q[$];
  sqrt_request_t              next_req;
  sqrt_result_t               want;
  logic [nsr_pkg::TOL_W-1:0]  tolerance_setting = nsr_pkg::TOL_RESET;
  bit                         item_in_flight = 1'b0;
  bit                         send_calm = 1'b0;
  bit                         recv_calm = 1'b0;
  int                         send_wait = 0;
  int                         stall_left = 0;
  int                         quiet_cycles = 0;
  int                         mismatch_count = 0;

  newton_square_root_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .radicand_i        (radicand_i),
    .start_guess_i     (start_guess_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .root_o            (root_o),
    .status_o          (status_o),
    .iterations_used_o (iterations_used_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Newton iteration with exact numerator, truncating divide and saturating update
  function automatic sqrt_result_t predict_sqrt(
      input logic signed [nsr_pkg::WORD_W-1:0] rad,
      input logic signed [nsr_pkg::WORD_W-1:0] guess,
      input logic [nsr_pkg::TOL_W-1:0] tol);
    sqrt_result_t               r;
    longint                     v;
    longint                     x0;
    longint                     x1;
    longint                     q;
    longint                     d;
    longint unsigned            ax;
    longint unsigned            sq;
    longint unsigned            vs;
    longint unsigned            nm;
    longint unsigned            qm;
    longint unsigned            dm;
    bit                         num_neg;
    bit                         q_neg;
    bit                         done;
    logic [nsr_pkg::ITER_W-1:0] steps;
    v = rad;
    x0 = guess;
    x1 = 0;
    steps = '0;
    done = 1'b0;
    if (v == 0) begin
      r.status = nsr_pkg::ST_ZERO_INPUT;
    end else if (v < 0) begin
      r.status = nsr_pkg::ST_NEGATIVE;
    end else begin
      if (x0 == 0) x0 = longint'(1) << FRAC;
      r.status = nsr_pkg::ST_LIMIT;
      while (!done && steps < ITER_LIMIT) begin
        if (x0 == 0) begin
          r.status = nsr_pkg::ST_ZERO_DIV;
          x1 = 0;
          done = 1'b1;
        end else begin
          ax = (x0 < 0) ? -x0 : x0;
          sq = ax * ax;
          vs = v << FRAC;
          num_neg = sq < vs;
          nm = num_neg ? vs - sq : sq - vs;
          qm = nm / (ax << 1);
          q_neg = num_neg != (x0 < 0);
          q = q_neg ? -$signed(qm) : $signed(qm);
          x1 = x0 - q;
          if (x1 > ROOT_MAX) x1 = ROOT_MAX;
          else if (x1 < ROOT_MIN) x1 = ROOT_MIN;
          steps = steps + 1'b1;
          d = x1 - x0;
          dm = (d < 0) ? -d : d;
          if (dm < tol) begin
            r.status = nsr_pkg::ST_CONVERGED;
            done = 1'b1;
          end else begin
            x0 = x1;
          end
        end
      end
    end
    r.root = x1[nsr_pkg::WORD_W-1:0];
    r.iters = steps;
    return r;
  endfunction

  function automatic sqrt_request_t make_request();
    sqrt_request_t req;
    int unsigned   span;
    real           root_est;
    case ($urandom_range(15, 0))
      0: req.radicand = '0;
      1: req.radicand = $urandom | 32'h8000_0000;
      default: begin
        span = $urandom_range(31, 1);
        req.radicand = $urandom & ((32'd1 << span) - 32'd1);
        if (req.radicand == 0) req.radicand = 32'sd1;
      end
    endcase
    case ($urandom_range(7, 0))
      0: req.guess = '0;
      1: req.guess = $urandom;
      2, 3: begin
        span = $urandom_range(20, 1);
        req.guess = $urandom & ((32'd1 << span) - 32'd1);
      end
      default: begin
        // start near the true root so many transactions stay short
        if (req.radicand > 0) begin
          root_est = $sqrt(real'(req.radicand) / 65536.0) * 65536.0;
          req.guess = int'(root_est) + $urandom_range(4096, 0) - 2048;
        end else begin
          req.guess = $urandom;
        end
      end
    endcase
    if ($urandom_range(1, 0) == 1) req.guess = -req.guess;
    return req;
  endfunction

  task automatic queue_item(input logic [nsr_pkg::WORD_W-1:0] rad,
                            input logic [nsr_pkg::WORD_W-1:0] guess);
    sqrt_request_t req;
    req.radicand = rad;
    req.guess = guess;
    request_q.push_back(req);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) request_q.push_back(make_request());
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || item_in_flight || expected_roots_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [nsr_pkg::TOL_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tolerance_setting = value;
  endtask

  // Driver: presents queued requests, with a random gap after each transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait <= 0;
      item_in_flight = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_roots_q.push_back(predict_sqrt(radicand_i, start_guess_i, tolerance_setting));
        item_in_flight = 1'b0;
        if ($urandom_range(31, 0) == 0) send_calm = !send_calm;
      end
      if (!item_in_flight) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          radicand_i <= next_req.radicand;
          start_guess_i <= next_req.guess;
          in_valid_i <= 1'b1;
          item_in_flight = 1'b1;
          send_wait <= send_calm ? 0 : $urandom_range(15, 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then stalls at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_roots_q.size() == 0) begin
          $display("%0t: unexpected result: root %h status %0d iterations %0d",
                   $time, root_o, status_o, iterations_used_o);
          mismatch_count++;
        end else begin
          want = expected_roots_q.pop_front();
          if (root_o !== want.root) begin
            $display("%0t: root mismatch: expected %h, actual %h", $time, want.root, root_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_o);
            mismatch_count++;
          end
          if (iterations_used_o !== want.iters) begin
            $display("%0t: iterations mismatch: expected %0d, actual %0d",
                     $time, want.iters, iterations_used_o);
            mismatch_count++;
          end
        end
        if ($urandom_range(31, 0) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(15, 0);
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [nsr_pkg::TOL_W-1:0] tol_pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cases at the reset tolerance
    queue_item(32'h0000_0000, 32'h0000_0000);
    queue_item(32'h0000_0000, 32'h7FFF_FFFF);
    queue_item(32'hFFFF_FFFF, 32'h0001_0000);
    queue_item(32'h8000_0000, 32'h8000_0000);
    queue_item(32'h0001_0000, 32'h0001_0000);
    queue_item(32'h0004_0000, 32'h0000_0000);
    queue_item(32'h0004_0000, 32'hFFFF_0000);
    queue_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_item(32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(32'h7FFF_FFFF, 32'h0000_0001);
    queue_item(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_item(32'h0000_0001, 32'h0000_0000);
    queue_item(32'h0000_0001, 32'h7FFF_FFFF);
    queue_item(32'h0002_0000, 32'h0001_6A0A);
    queue_item(32'h0009_0000, 32'h0003_0000);
    wait_idle();

    // zero tolerance never converges: every positive radicand runs to the limit
    set_tolerance('0);
    queue_item(32'h0009_0000, 32'h0003_0000);
    queue_random(8);
    wait_idle();

    set_tolerance('1);
    queue_random(100);
    wait_idle();

    set_tolerance(16'd1);
    queue_random(300);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      tol_pick = ($urandom_range(2, 0) == 0) ? $urandom_range(65535, 1)
                                             : $urandom_range(256, 1);
      set_tolerance(tol_pick);
      queue_random(55);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
